>>> rtl/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

  // Operation codes carried on func_i
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  // Result status codes
  localparam int unsigned STATUS_W = 2;
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd2;

  // Broadcast command to every cell of the row
  typedef struct packed {
    logic ins;  // insert the new entry, shifting entries of equal or larger priority up
    logic rem;  // drop the head, shifting every entry down
  } cell_op_t;

endpackage

>>> rtl/sorted_priority_queue_top.sv
// The result of an accepted transfer appears on the output register in the following cycle.
// Throughput: one operation per cycle when not stalled; every cell compares and shifts in the same cycle.
// Cost per operation is one priority compare in each cell plus the row-wide shift.
// Reset (rst_ni low, asynchronous) empties the queue and drops any pending result;
// slot contents and the reported occupancy are not cleared, only the entry count.
`timescale 1ns / 1ps

module sorted_priority_queue_top #(
  parameter int unsigned CAPACITY       = 16,
  parameter int unsigned VALUE_WIDTH    = 16,
  parameter int unsigned PRIORITY_WIDTH = 16,
  localparam int unsigned CNT_W         = $clog2(CAPACITY + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          func_i,
  input  logic [VALUE_WIDTH-1:0]        item_value_i,
  input  logic [PRIORITY_WIDTH-1:0]     item_priority_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [VALUE_WIDTH-1:0]        head_value_o,
  output logic [spq_pkg::STATUS_W-1:0]  status_o,
  output logic                          now_empty_o,
  output logic [CNT_W-1:0]              occupancy_o
);

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // Entry count, the only control state of the row
  logic [CNT_W-1:0] count_q, count_d;

  // Output register: holds one finished result until the sink takes it
  logic                         out_valid_q, out_valid_d;
  logic [VALUE_WIDTH-1:0]       head_value_q, head_value_d;
  logic [spq_pkg::STATUS_W-1:0] status_q, status_d;
  logic [CNT_W-1:0]             occupancy_q;

  logic               accept;
  logic               full, empty;
  spq_pkg::cell_op_t  op;

  // Cell row wiring
  logic [CAPACITY-1:0]       occupied;
  logic [CAPACITY-1:0]       go;
  logic [VALUE_WIDTH-1:0]    cell_value [CAPACITY];
  logic [PRIORITY_WIDTH-1:0] cell_priority [CAPACITY];

  // Stall the source only while a result waits and the sink is stalling
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign full  = (count_q == CAP_CNT);
  assign empty = (count_q == '0);

  // Broadcast the command; refused operations leave the row untouched
  always_comb begin
    op.ins = accept && (func_i == spq_pkg::FUNC_INSERT) && !full;
    op.rem = accept && (func_i == spq_pkg::FUNC_REMOVE) && !empty;
  end

  // Advance the count and build the result
  always_comb begin
    count_d      = count_q;
    head_value_d = head_value_q;
    status_d     = status_q;
    out_valid_d  = out_valid_q && out_stall_i;
    if (accept) begin
      out_valid_d  = 1'b1;
      head_value_d = '0;
      status_d     = spq_pkg::STATUS_OK;
      if (func_i == spq_pkg::FUNC_INSERT) begin
        if (full) begin
          status_d = spq_pkg::STATUS_OVERFLOW;
        end else begin
          count_d = count_q + 1'b1;
        end
      end else begin
        if (empty) begin
          status_d = spq_pkg::STATUS_UNDERFLOW;
        end else begin
          head_value_d = cell_value[0];
          count_d      = count_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload of the result: no reset needed
  always_ff @(posedge clk_i) begin
    head_value_q <= head_value_d;
    status_q     <= status_d;
    if (accept) begin
      occupancy_q <= count_d;
    end
  end

  // Row of cells; slot 0 holds the head. Each cell sees its neighbours plus the broadcast command and new entry.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                      prev_go;
    logic [VALUE_WIDTH-1:0]    prev_value, next_value;
    logic [PRIORITY_WIDTH-1:0] prev_priority, next_priority;

    assign occupied[i] = (CNT_W'(i) < count_q);

    if (i == 0) begin : g_first
      assign prev_go       = 1'b0;
      assign prev_value    = item_value_i;
      assign prev_priority = item_priority_i;
    end else begin : g_mid
      assign prev_go       = go[i-1];
      assign prev_value    = cell_value[i-1];
      assign prev_priority = cell_priority[i-1];
    end

    // The top slot keeps its own contents on a remove: it then lies past the count
    if (i == CAPACITY - 1) begin : g_last
      assign next_value    = cell_value[i];
      assign next_priority = cell_priority[i];
    end else begin : g_inner
      assign next_value    = cell_value[i+1];
      assign next_priority = cell_priority[i+1];
    end

    spq_cell #(
      .VALUE_WIDTH    (VALUE_WIDTH),
      .PRIORITY_WIDTH (PRIORITY_WIDTH)
    ) u_cell (
      .clk_i           (clk_i),
      .op_i            (op),
      .occupied_i      (occupied[i]),
      .new_value_i     (item_value_i),
      .new_priority_i  (item_priority_i),
      .prev_go_i       (prev_go),
      .prev_value_i    (prev_value),
      .prev_priority_i (prev_priority),
      .next_value_i    (next_value),
      .next_priority_i (next_priority),
      .go_o            (go[i]),
      .value_o         (cell_value[i]),
      .priority_o      (cell_priority[i])
    );
  end

  assign out_valid_o  = out_valid_q;
  assign head_value_o = head_value_q;
  assign status_o     = status_q;
  assign occupancy_o  = occupancy_q;
  assign now_empty_o  = (occupancy_q == '0);

  // The count never passes the capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP_CNT)
    else $error("entry count above capacity");

  // A remove on an empty queue reports underflow and leaves the count at zero
  a_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && func_i == spq_pkg::FUNC_REMOVE && empty)
      |=> (status_q == spq_pkg::STATUS_UNDERFLOW) && (count_q == '0))
    else $error("empty remove not reported as underflow");

  // An accepted insert into a non-full queue grows the count by one
  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && func_i == spq_pkg::FUNC_INSERT && !full)
      |=> (count_q == $past(count_q) + 1'b1) && (status_q == spq_pkg::STATUS_OK))
    else $error("insert did not advance count");

  // The reported occupancy follows the count once a result is presented
  a_occ_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(accept) |-> (occupancy_q == count_q))
    else $error("occupancy out of step with count");

endmodule

>>> rtl/spq_cell.sv
`timescale 1ns / 1ps

module spq_cell #(
  parameter int unsigned VALUE_WIDTH    = 16,
  parameter int unsigned PRIORITY_WIDTH = 16
) (
  input  logic                      clk_i,
  input  spq_pkg::cell_op_t         op_i,
  input  logic                      occupied_i,
  input  logic [VALUE_WIDTH-1:0]    new_value_i,
  input  logic [PRIORITY_WIDTH-1:0] new_priority_i,
  input  logic                      prev_go_i,
  input  logic [VALUE_WIDTH-1:0]    prev_value_i,
  input  logic [PRIORITY_WIDTH-1:0] prev_priority_i,
  input  logic [VALUE_WIDTH-1:0]    next_value_i,
  input  logic [PRIORITY_WIDTH-1:0] next_priority_i,
  output logic                      go_o,
  output logic [VALUE_WIDTH-1:0]    value_o,
  output logic [PRIORITY_WIDTH-1:0] priority_o
);

  logic [VALUE_WIDTH-1:0]    value_q, value_d;
  logic [PRIORITY_WIDTH-1:0] priority_q, priority_d;

  // The new entry belongs at or below this slot
  assign go_o = !occupied_i || (new_priority_i <= priority_q);

  always_comb begin
    value_d    = value_q;
    priority_d = priority_q;
    if (op_i.rem) begin
      value_d    = next_value_i;
      priority_d = next_priority_i;
    end else if (op_i.ins && go_o) begin
      if (prev_go_i) begin
        value_d    = prev_value_i;
        priority_d = prev_priority_i;
      end else begin
        value_d    = new_value_i;
        priority_d = new_priority_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q    <= value_d;
    priority_q <= priority_d;
  end

  assign value_o    = value_q;
  assign priority_o = priority_q;

endmodule
